### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RC4_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### design/rc4_pkg.sv
package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic key_load;
        logic data_load;
        logic init_step;
        logic ks_rd;
        logic ks_acc;
        logic ks_wn;
        logic ks_wa;
        logic dt_i;
        logic dt_j;
        logic dt_t;
        logic dt_k;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic keyed;
        logic out_free;
        logic n_last;
    } status_t;

endpackage

### design/rc4_stream_if.sv
interface rc4_in_if;
    logic                valid;
    logic                ready;
    logic                mode;
    rc4_pkg::byte_t      data_byte;
    logic                last_key_byte;

    modport source (output valid, output mode, output data_byte, output last_key_byte,
                    input ready);
    modport sink (input valid, input mode, input data_byte, input last_key_byte,
                  output ready);
endinterface

interface rc4_out_if;
    logic                valid;
    logic                ready;
    rc4_pkg::byte_t      out_byte;
    logic                not_keyed;

    modport source (output valid, output out_byte, output not_keyed, input ready);
    modport sink (input valid, input out_byte, input not_keyed, output ready);
endinterface

### design/rc4_ram.sv
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/rc4_datapath.sv
module rc4_datapath #(
    parameter int KEY_MAX = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rc4_pkg::cmd_t       cmd,
    input  rc4_pkg::byte_t      in_byte,
    input  logic                out_ready,
    output rc4_pkg::status_t    status,
    output logic                out_valid,
    output rc4_pkg::byte_t      out_byte,
    output logic                out_not_keyed
);

    localparam int KA_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KL_W = $clog2(KEY_MAX + 1);

    // permutation memory port
    logic                              p_we;
    logic [rc4_pkg::PERM_AW-1:0]       p_waddr;
    rc4_pkg::byte_t                    p_wdata;
    logic                              p_re;
    logic [rc4_pkg::PERM_AW-1:0]       p_raddr;
    rc4_pkg::byte_t                    s_rdata;

    // key memory port
    logic                              k_we;
    logic                              k_re;
    rc4_pkg::byte_t                    k_rdata;

    logic [KL_W-1:0]      key_len_reg, key_len_next;
    logic [KL_W-1:0]      len_eff;
    logic [KL_W-1:0]      kidx_inc;
    logic [KA_W-1:0]      kidx_reg, kidx_next;
    rc4_pkg::byte_t       n_reg, n_next;
    rc4_pkg::byte_t       acc_reg, acc_next;
    rc4_pkg::byte_t       acc_new;
    rc4_pkg::byte_t       i_reg, i_next;
    rc4_pkg::byte_t       j_reg, j_next;
    rc4_pkg::byte_t       j_new;
    rc4_pkg::byte_t       sn_reg, sn_next;
    rc4_pkg::byte_t       si_reg, si_next;
    rc4_pkg::byte_t       sj_reg, sj_next;
    rc4_pkg::byte_t       t_reg, t_next;
    rc4_pkg::byte_t       ks_reg, ks_next;
    rc4_pkg::byte_t       byte_reg, byte_next;
    rc4_pkg::byte_t       out_byte_reg, out_byte_next;
    logic                 nk_reg, nk_next;
    logic                 keyed_reg, keyed_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 ks_done;

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::PERM_DEPTH)
    ) u_perm_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (s_rdata)
    );

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (KEY_MAX)
    ) u_key_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (key_len_reg[KA_W-1:0]),
        .wdata (in_byte),
        .re    (k_re),
        .raddr (kidx_reg),
        .rdata (k_rdata)
    );

    assign ks_done  = cmd.ks_wa && status.n_last;
    assign acc_new  = acc_reg + s_rdata + k_rdata;
    assign j_new    = j_reg + s_rdata;
    assign len_eff  = (key_len_reg == '0) ? KL_W'(1) : key_len_reg;
    assign kidx_inc = KL_W'(kidx_reg) + KL_W'(1);
    assign k_we     = cmd.key_load && (key_len_reg < KL_W'(KEY_MAX));
    assign k_re     = cmd.ks_rd;

    always_comb
    begin
        p_we    = 1'b0;
        p_waddr = '0;
        p_wdata = '0;
        if (cmd.init_step)
        begin
            p_we    = 1'b1;
            p_waddr = n_reg;
            p_wdata = n_reg;
        end
        else if (cmd.ks_wn)
        begin
            p_we    = 1'b1;
            p_waddr = n_reg;
            p_wdata = s_rdata;
        end
        else if (cmd.ks_wa)
        begin
            p_we    = 1'b1;
            p_waddr = acc_reg;
            p_wdata = sn_reg;
        end
        else if (cmd.dt_t)
        begin
            p_we    = 1'b1;
            p_waddr = i_reg;
            p_wdata = s_rdata;
        end
        else if (cmd.dt_k)
        begin
            p_we    = 1'b1;
            p_waddr = j_reg;
            p_wdata = si_reg;
        end
    end

    always_comb
    begin
        p_re    = 1'b1;
        p_raddr = '0;
        if (cmd.ks_rd)
        begin
            p_raddr = n_reg;
        end
        else if (cmd.ks_acc)
        begin
            p_raddr = acc_new;
        end
        else if (cmd.dt_i)
        begin
            p_raddr = i_reg + 8'd1;
        end
        else if (cmd.dt_j)
        begin
            p_raddr = j_new;
        end
        else if (cmd.dt_t)
        begin
            p_raddr = si_reg + s_rdata;
        end
        else
        begin
            p_re = 1'b0;
        end
    end

    always_comb
    begin
        key_len_next   = key_len_reg;
        kidx_next      = kidx_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        sn_next        = sn_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        t_next         = t_reg;
        ks_next        = ks_reg;
        byte_next      = byte_reg;
        out_byte_next  = out_byte_reg;
        nk_next        = nk_reg;
        keyed_next     = keyed_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (k_we)
        begin
            key_len_next = key_len_reg + KL_W'(1);
        end
        if (cmd.data_load)
        begin
            byte_next = in_byte;
        end
        if (cmd.init_step)
        begin
            n_next    = n_reg + 8'd1;
            acc_next  = '0;
            kidx_next = '0;
        end
        if (cmd.ks_acc)
        begin
            acc_next = acc_new;
            sn_next  = s_rdata;
        end
        if (cmd.ks_wa)
        begin
            n_next    = n_reg + 8'd1;
            kidx_next = (kidx_inc == len_eff) ? '0 : kidx_inc[KA_W-1:0];
        end
        if (ks_done)
        begin
            i_next       = '0;
            j_next       = '0;
            keyed_next   = 1'b1;
            key_len_next = '0;
        end
        if (cmd.dt_i)
        begin
            i_next = i_reg + 8'd1;
        end
        if (cmd.dt_j)
        begin
            si_next = s_rdata;
            j_next  = j_new;
        end
        if (cmd.dt_t)
        begin
            sj_next = s_rdata;
            t_next  = si_reg + s_rdata;
        end
        if (cmd.dt_k)
        begin
            // entries i and j were just swapped, the memory still shows old values there
            if (t_reg == j_reg)
            begin
                ks_next = si_reg;
            end
            else if (t_reg == i_reg)
            begin
                ks_next = sj_reg;
            end
            else
            begin
                ks_next = s_rdata;
            end
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = keyed_reg ? (byte_reg ^ ks_reg) : byte_reg;
            nk_next        = !keyed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg   <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_len_reg   <= key_len_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kidx_reg     <= kidx_next;
        acc_reg      <= acc_next;
        sn_reg       <= sn_next;
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        t_reg        <= t_next;
        ks_reg       <= ks_next;
        byte_reg     <= byte_next;
        out_byte_reg <= out_byte_next;
        nk_reg       <= nk_next;
    end

    assign status.keyed    = keyed_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.n_last   = (n_reg == 8'hFF);

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_not_keyed = nk_reg;

endmodule

### design/rc4_ctrl.sv
module rc4_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_mode,
    input  logic                in_last,
    input  rc4_pkg::status_t    status,
    output logic                in_ready,
    output rc4_pkg::cmd_t       cmd
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_INIT   = 11'b000_0000_0010,
        ST_KS_RD  = 11'b000_0000_0100,
        ST_KS_ACC = 11'b000_0000_1000,
        ST_KS_WN  = 11'b000_0001_0000,
        ST_KS_WA  = 11'b000_0010_0000,
        ST_DT_I   = 11'b000_0100_0000,
        ST_DT_J   = 11'b000_1000_0000,
        ST_DT_T   = 11'b001_0000_0000,
        ST_DT_K   = 11'b010_0000_0000,
        ST_EMIT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!in_mode)
                    begin
                        cmd.key_load = 1'b1;
                        if (in_last)
                        begin
                            state_next = ST_INIT;
                        end
                    end
                    else
                    begin
                        cmd.data_load = 1'b1;
                        state_next    = status.keyed ? ST_DT_I : ST_EMIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (status.n_last)
                begin
                    state_next = ST_KS_RD;
                end
            end
            ST_KS_RD:
            begin
                cmd.ks_rd  = 1'b1;
                state_next = ST_KS_ACC;
            end
            ST_KS_ACC:
            begin
                cmd.ks_acc = 1'b1;
                state_next = ST_KS_WN;
            end
            ST_KS_WN:
            begin
                cmd.ks_wn  = 1'b1;
                state_next = ST_KS_WA;
            end
            ST_KS_WA:
            begin
                cmd.ks_wa  = 1'b1;
                state_next = status.n_last ? ST_IDLE : ST_KS_RD;
            end
            ST_DT_I:
            begin
                cmd.dt_i   = 1'b1;
                state_next = ST_DT_J;
            end
            ST_DT_J:
            begin
                cmd.dt_j   = 1'b1;
                state_next = ST_DT_T;
            end
            ST_DT_T:
            begin
                cmd.dt_t   = 1'b1;
                state_next = ST_DT_K;
            end
            ST_DT_K:
            begin
                cmd.dt_k   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/rc4_keystream_cipher_unit.sv
// RC4 stream cipher engine. Key bytes (mode 0) are taken one per cycle and produce no
// transaction on the output; the byte flagged last_key_byte starts the key schedule, which
// holds din.ready low while it loads the identity permutation and then runs 256 swap steps,
// each a read, an accumulate and two writes, since the 256-entry permutation RAM has one
// write port and one registered read port. Key bytes past KEY_MAX are dropped. A data byte
// (mode 1) is XORed with the next keystream byte; the next data byte is not taken before
// four dependent RAM steps for the keystream swap and the output load, which waits for a
// free output register. Before any key is scheduled only the output load is done, and
// the byte passes through with not_keyed set. One result waits in the output register
// while the next key byte may already be taken.
module rc4_keystream_cipher_unit #(
    parameter int KEY_MAX = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    rc4_in_if.sink         din,
    rc4_out_if.source      dout
);

    rc4_pkg::cmd_t    cmd;
    rc4_pkg::status_t status;

    rc4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_mode  (din.mode),
        .in_last  (din.last_key_byte),
        .status   (status),
        .in_ready (din.ready),
        .cmd      (cmd)
    );

    rc4_datapath #(
        .KEY_MAX (KEY_MAX)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_byte       (din.data_byte),
        .out_ready     (dout.ready),
        .status        (status),
        .out_valid     (dout.valid),
        .out_byte      (dout.out_byte),
        .out_not_keyed (dout.not_keyed)
    );

endmodule

### design/rc4_checker.sv
`include "assert_macros.svh"

module rc4_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           in_mode,
    input logic           out_valid,
    input logic           out_ready,
    input rc4_pkg::byte_t out_byte,
    input logic           not_keyed
);

    `RC4_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `RC4_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
                     $stable(out_byte) && $stable(not_keyed))
    `RC4_ASSERT_NEXT(a_busy_after_data, clk, rst_n, in_valid && in_ready && in_mode, !in_ready)
    `RC4_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind rc4_keystream_cipher_unit rc4_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .in_mode   (din.mode),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_byte  (dout.out_byte),
    .not_keyed (dout.not_keyed)
);
